// ----- hw/rtl/ita_pkg.sv -----
package ita_pkg;

   // format selector codes
   localparam logic ACTION_DEC = 1'b0;
   localparam logic ACTION_HEX = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic neg;
      logic hex;
   } item_ctl_type;

endpackage

// ----- hw/rtl/ita_front.sv -----
module ita_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                       req_action,
   output logic                       q_valid,
   input  logic                       q_ready,
   output logic [VALUE_WIDTH-1:0]     q_mag,
   output ita_pkg::item_ctl_type      q_ctl
);

   localparam int PTR_W = $clog2(ita_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ita_pkg::QUEUE_DEPTH + 1);

   logic [VALUE_WIDTH-1:0]  value_bits;
   logic [VALUE_WIDTH-1:0]  mag;
   ita_pkg::item_ctl_type   ctl;

   logic [VALUE_WIDTH-1:0]  mag_mem [ita_pkg::QUEUE_DEPTH];
   ita_pkg::item_ctl_type   ctl_mem [ita_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push, pop;

   // classify: sign only counts in decimal mode, magnitude taken as unsigned
   assign value_bits = req_value;
   assign ctl.hex    = (req_action == ita_pkg::ACTION_HEX);
   assign ctl.neg    = (req_action == ita_pkg::ACTION_DEC) && value_bits[VALUE_WIDTH-1];
   assign mag        = ctl.neg ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

   assign req_ready = (count_ff != CNT_W'(ita_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign q_mag     = mag_mem[rd_ptr_ff];
   assign q_ctl     = ctl_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ita_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ita_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mag_mem[wr_ptr_ff] <= mag;
         ctl_mem[wr_ptr_ff] <= ctl;
      end
   end

endmodule

// ----- hw/rtl/ita_back.sv -----
module ita_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  logic [VALUE_WIDTH-1:0]  q_mag,
   input  ita_pkg::item_ctl_type   q_ctl,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_last
);

   // decimal digits of the largest magnitude, ceil(w * log10 2)
   localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NSTEP = (VALUE_WIDTH + 3) / 4;
   localparam int PW    = NSTEP * 4;
   localparam int DW    = NDIG * 4;
   localparam int LW    = $clog2(NDIG + 1);
   localparam int SW    = $clog2(NSTEP + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [3:0] DEC_BASE   = 4'd10;
   localparam logic [3:0] DD_LIMIT   = 4'd5;
   localparam logic [3:0] DD_ADJ     = 4'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SKIP,
      S_PREFIX,
      S_DIGIT
   } state_type;

   state_type               state_ff;
   ita_pkg::item_ctl_type   ctl_ff;
   logic [PW-1:0]           shift_ff;
   logic [DW-1:0]           digits_ff;
   logic [SW-1:0]           step_ff;
   logic [LW-1:0]           left_ff;
   logic                    pre_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              char_ff;
   logic                    last_ff;

   logic [PW-1:0]           conv_shift;
   logic [DW-1:0]           conv_bcd;
   logic [3:0]              top_digit;
   logic                    emit_ok;
   logic                    emit_now;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      if (d < DEC_BASE) begin
         return CHAR_ZERO + {4'b0, d};
      end
      return CHAR_A + {4'b0, d - DEC_BASE};
   endfunction

   // shift-add-3 binary to bcd, four bits per cycle
   always_comb begin
      logic [DW-1:0] bcd;
      logic [PW-1:0] sh;
      bcd = digits_ff;
      sh  = shift_ff;
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < NDIG; j++) begin
            if (bcd[j*4 +: 4] >= DD_LIMIT) begin
               bcd[j*4 +: 4] = bcd[j*4 +: 4] + DD_ADJ;
            end
         end
         bcd = {bcd[DW-2:0], sh[PW-1]};
         sh  = {sh[PW-2:0], 1'b0};
      end
      conv_bcd   = bcd;
      conv_shift = sh;
   end

   assign top_digit    = digits_ff[DW-1 -: 4];
   assign emit_ok      = !rsp_valid_ff || rsp_ready;
   // a new character replaces the one just taken
   assign emit_now     = emit_ok && (state_ff == S_PREFIX || state_ff == S_DIGIT);
   assign q_ready      = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  ctl_ff <= q_ctl;
                  pre_ff <= 1'b0;
                  if (q_ctl.hex) begin
                     // hex digits are the nibbles, left-justified
                     digits_ff <= {PW'(q_mag), {(DW - PW){1'b0}}};
                     left_ff   <= LW'(NSTEP);
                     state_ff  <= S_SKIP;
                  end else begin
                     digits_ff <= '0;
                     shift_ff  <= PW'(q_mag);
                     step_ff   <= SW'(NSTEP);
                     state_ff  <= S_CONV;
                  end
               end
            end
            S_CONV: begin
               digits_ff <= conv_bcd;
               shift_ff  <= conv_shift;
               step_ff   <= step_ff - SW'(1);
               left_ff   <= LW'(NDIG);
               if (step_ff == SW'(1)) begin
                  state_ff <= S_SKIP;
               end
            end
            S_SKIP: begin
               // strip leading zeros, always keep one digit
               if (left_ff != LW'(1) && top_digit == 4'd0) begin
                  digits_ff <= {digits_ff[DW-5:0], 4'd0};
                  left_ff   <= left_ff - LW'(1);
               end else if (ctl_ff.hex || ctl_ff.neg) begin
                  state_ff <= S_PREFIX;
               end else begin
                  state_ff <= S_DIGIT;
               end
            end
            S_PREFIX: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= 1'b0;
                  pre_ff       <= 1'b1;
                  if (!ctl_ff.hex) begin
                     char_ff <= CHAR_MINUS;
                  end else begin
                     char_ff <= pre_ff ? CHAR_X : CHAR_ZERO;
                  end
                  if (!ctl_ff.hex || pre_ff) begin
                     state_ff <= S_DIGIT;
                  end
               end
            end
            S_DIGIT: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  char_ff      <= digit_char(top_digit);
                  last_ff      <= (left_ff == LW'(1));
                  digits_ff    <= {digits_ff[DW-5:0], 4'd0};
                  left_ff      <= left_ff - LW'(1);
                  if (left_ff == LW'(1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Prints one integer per transfer as ASCII text, one character per result
// transfer, most significant first, with rsp_last on the final character.
// Decimal mode (action 0) is signed with a leading '-', hex mode (action 1)
// prints the raw bits as "0x" and lower-case digits; leading zeros are
// stripped, keeping at least one digit. A two-entry queue sits between the
// input side and the formatter, so up to two numbers can be taken while text
// is still going out. Each number is handled on its own: a decimal item is
// loaded, passes through the shift-add-3 bcd converter four bits at a time,
// then has its leading zero digits stripped (at most 9 at 32 bits), and its
// characters are sent; hex items skip the converter. The output register
// sends one character per cycle while rsp_ready is high.
module integer_to_ascii_formatter #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          req_action,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last
);

   logic                    q_valid;
   logic                    q_ready;
   logic [VALUE_WIDTH-1:0]  q_mag;
   ita_pkg::item_ctl_type   q_ctl;

   ita_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .req_action(req_action),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_mag     (q_mag),
      .q_ctl     (q_ctl)
   );

   ita_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_mag       (q_mag),
      .q_ctl       (q_ctl),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_char(rsp_out_char),
      .rsp_last    (rsp_last)
   );

endmodule

// ----- hw/rtl/ita_checker.sv -----
module ita_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last
);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X     = 8'h78;

   // nothing left over from before reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("stalled result changed");

   // a number always ends in a digit
   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_out_char >= CHAR_ZERO && rsp_out_char <= CHAR_NINE) ||
         (rsp_out_char >= CHAR_A && rsp_out_char <= CHAR_F))
      else $error("last character is not a digit");

   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_char == CHAR_MINUS || rsp_out_char == CHAR_X) |-> !rsp_last)
      else $error("prefix character flagged last");

   // only digits, letters a to f, minus and x are ever sent
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_out_char >= CHAR_ZERO && rsp_out_char <= CHAR_NINE) ||
         (rsp_out_char >= CHAR_A && rsp_out_char <= CHAR_F) ||
         rsp_out_char == CHAR_MINUS || rsp_out_char == CHAR_X)
      else $error("unexpected character");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_char(rsp_out_char),
   .rsp_last    (rsp_last)
);
